FILE: rtl/lag_pkg.sv
// Shared types, constants and the cell update rule for the life automaton block.
package lag_pkg;

  // Default grid bounds for the parameters
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Field widths fixed by the item format
  localparam int CMD_W       = 2;
  localparam int ROW_FIELD_W = 6;
  localparam int COL_FIELD_W = 6;

  // Configuration registers
  localparam int                   CFG_W     = 7;
  localparam int                   CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0]     CFG_RESET = 7'd64;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

  // Update rule
  localparam int NBR_W         = 4;
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [ROW_FIELD_W-1:0] cell_row;
    logic [COL_FIELD_W-1:0] cell_col;
    logic                   cell_value;
  } lag_in_t;

  typedef struct packed {
    logic read_value;
    logic range_error;
  } lag_out_t;

  // Engine status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } lag_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_ADV_LOAD,
    ST_ADV_STEP,
    ST_DONE
  } lag_state_t;

  // Birth on three live neighbors, survival on two or three
  function automatic logic life_rule(input logic alive, input logic [NBR_W-1:0] count);
    logic born;
    logic keep;
    born = (count == NBR_W'(BIRTH_COUNT));
    keep = alive && (count == NBR_W'(SURVIVE_COUNT));
    return born || keep;
  endfunction

endpackage

FILE: rtl/lag_engine.sv
// Row-wide grid memory with the sequencer for cell access, clearing and generation update.
module lag_engine
  import lag_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int RW  = $clog2(MAX_ROWS),
  localparam int CW  = $clog2(MAX_COLS),
  localparam int RCW = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W,
  localparam int CCW = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  lag_in_t        item,
  input  logic [RCW-1:0] eff_rows,
  input  logic [CCW-1:0] eff_cols,
  input  logic           res_take,
  output lag_status_t    status,
  output lag_out_t       res
);

  // Grid store: one word per row, one bit per column
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data;
  logic                mem_we;
  logic [RW-1:0]       mem_waddr;
  logic [RW-1:0]       mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata;

  lag_state_t state;
  lag_state_t state_next;

  // Transaction registers
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic          val_q;
  logic          wr_q;
  lag_out_t      res_q;

  // Sweep counters and row window
  logic [RW-1:0]       clr_row;
  logic [RCW-1:0]      adv_row;
  logic [RCW-1:0]      adv_row_plus1;
  logic [RCW-1:0]      adv_row_plus2;
  logic [MAX_COLS-1:0] prev_row;
  logic [MAX_COLS-1:0] cur_row;

  logic                accept;
  logic                is_cell_cmd;
  logic                in_range;
  logic                grid_empty;
  logic                nxt_valid;
  logic                last_row;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] new_row;
  logic [MAX_COLS-1:0] cell_wdata;
  logic [MAX_COLS-1:0] step_wdata;
  logic [MAX_COLS+1:0] prev_pad;
  logic [MAX_COLS+1:0] cur_pad;
  logic [MAX_COLS+1:0] nxt_pad;

  // Memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Decode the incoming transaction
  assign accept      = item_valid && (state == ST_IDLE);
  assign is_cell_cmd = (item.cmd inside {CMD_WRITE, CMD_READ});
  assign in_range    = (RCW'(item.cell_row) < eff_rows) && (CCW'(item.cell_col) < eff_cols);
  assign grid_empty  = (eff_rows == '0) || (eff_cols == '0);

  // Row counter arithmetic for the update sweep
  assign adv_row_plus1 = adv_row + RCW'(1);
  assign adv_row_plus2 = adv_row + RCW'(2);
  assign nxt_valid     = (adv_row_plus1 < eff_rows);
  assign last_row      = (adv_row_plus1 == eff_rows);

  // Mask columns beyond the grid and pad with a dead border
  assign prev_pad = {1'b0, prev_row & col_mask, 1'b0};
  assign cur_pad  = {1'b0, cur_row & col_mask, 1'b0};
  assign nxt_pad  = {1'b0, (nxt_valid ? rd_data : '0) & col_mask, 1'b0};

  // Count neighbors and apply the rule per column
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    logic [NBR_W-1:0] nbr_cnt;
    assign col_mask[c] = (CCW'(c) < eff_cols);
    assign nbr_cnt = NBR_W'(prev_pad[c]) + NBR_W'(prev_pad[c+1]) + NBR_W'(prev_pad[c+2])
                   + NBR_W'(cur_pad[c]) + NBR_W'(cur_pad[c+2])
                   + NBR_W'(nxt_pad[c]) + NBR_W'(nxt_pad[c+1]) + NBR_W'(nxt_pad[c+2]);
    assign new_row[c] = life_rule(cur_pad[c+1], nbr_cnt);
  end

  // Keep stored bits beyond the grid untouched
  assign step_wdata = (new_row & col_mask) | (cur_row & ~col_mask);

  // Merge the written cell into its row
  always_comb begin
    cell_wdata        = rd_data;
    cell_wdata[col_q] = val_q;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = row_q;
    mem_wdata  = cell_wdata;
    mem_raddr  = RW'(item.cell_row);
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row;
        mem_wdata = '0;
        if (clr_row == RW'(MAX_ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          if (item.cmd == CMD_ADVANCE) begin
            mem_raddr  = '0;
            state_next = grid_empty ? ST_DONE : ST_ADV_LOAD;
          end else if (is_cell_cmd && in_range) begin
            state_next = ST_CELL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_CELL: begin
        mem_we     = wr_q;
        state_next = ST_DONE;
      end
      ST_ADV_LOAD: begin
        mem_raddr  = RW'(1);
        state_next = ST_ADV_STEP;
      end
      ST_ADV_STEP: begin
        mem_we    = 1'b1;
        mem_waddr = adv_row[RW-1:0];
        mem_wdata = step_wdata;
        mem_raddr = adv_row_plus2[RW-1:0];
        if (last_row) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (state == ST_CLEAR) begin
      clr_row <= clr_row + RW'(1);
    end
  end

  // Latch transaction fields and advance the row window
  always_ff @(posedge clk) begin
    if (accept) begin
      row_q             <= RW'(item.cell_row);
      col_q             <= CW'(item.cell_col);
      val_q             <= item.cell_value;
      wr_q              <= (item.cmd == CMD_WRITE);
      res_q.read_value  <= 1'b0;
      res_q.range_error <= is_cell_cmd && !in_range;
    end
    if ((state == ST_CELL) && !wr_q) begin
      res_q.read_value <= rd_data[col_q];
    end
    if (state == ST_ADV_LOAD) begin
      prev_row <= '0;
      cur_row  <= rd_data;
      adv_row  <= '0;
    end
    if (state == ST_ADV_STEP) begin
      prev_row <= cur_row;
      cur_row  <= rd_data;
      adv_row  <= adv_row_plus1;
    end
  end

  assign status.idle = (state == ST_IDLE);
  assign status.done = (state == ST_DONE);
  assign res         = res_q;

endmodule

FILE: rtl/life_automaton_generation.sv
// Top level of the life automaton: configuration registers, input handshake, result register.
// Holds a grid of up to MAX_ROWS by MAX_COLS cells in one memory of MAX_ROWS words, one
// MAX_COLS-bit word per row, and runs one transaction at a time. A write or read goes from
// acceptance to the result register through a memory read, a merge or select, and a handoff;
// a coordinate outside the configured grid or an unused command skips the memory access. An
// advance sweeps the rows in use with a three-row window, reading one row and writing one row
// per cycle; on a grid with no rows or no columns it skips the sweep. After reset the block
// clears the memory, one row per cycle, until all MAX_ROWS rows are clear, and holds in_stall
// high meanwhile; configuration writes are taken at any time.
module life_automaton_generation
  import lag_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lag_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lag_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int RCW = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
  localparam int CCW = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;
  logic [RCW-1:0]   eff_rows;
  logic [CCW-1:0]   eff_cols;
  lag_status_t      status;
  lag_out_t         res;
  logic             res_take;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= CFG_RESET;
      grid_cols <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows <= cfg_data;
        REG_GRID_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate the grid size at the storage bounds
  assign eff_rows = (RCW'(grid_rows) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(grid_rows);
  assign eff_cols = (CCW'(grid_cols) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(grid_cols);

  lag_engine #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .item_valid(in_valid),
    .item      (in_data),
    .eff_rows  (eff_rows),
    .eff_cols  (eff_cols),
    .res_take  (res_take),
    .status    (status),
    .res       (res)
  );

  // Take a new transaction only while the engine is idle
  assign in_stall = !status.idle;

  // Output register: load when empty or draining
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.done && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done && res_take) begin
      out_data <= res;
    end
  end

endmodule

FILE: verif/life_automaton_generation_tb.sv
// Self-checking testbench for the life automaton grid: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module life_automaton_generation_tb;
  import lag_pkg::*;

  localparam int GRID_R          = MAX_ROWS_DEF;
  localparam int GRID_C          = MAX_COLS_DEF;
  localparam int N_PHASES        = 10;
  localparam int OPS_PER_PHASE   = 175;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    bit                  is_cfg;
    logic [CFG_W-1:0]    rows;
    logic [CFG_W-1:0]    cols;
    lag_in_t             op;
    bit                  known;
    lag_out_t            want;
  } plan_row_t;

  typedef struct {
    bit       known;
    lag_out_t want;
  } typed_want_t;

  typedef struct {
    lag_in_t  op;
    lag_out_t want;
  } cell_expect_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lag_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lag_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_ROWS;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predictor state: current generation and size registers
  bit [GRID_C-1:0]  life_rows [GRID_R];
  logic [CFG_W-1:0] cfg_rows;
  logic [CFG_W-1:0] cfg_cols;

  cell_expect_t expected_results [$];
  typed_want_t  typed_wants [$];
  plan_row_t    plan [$];

  int mismatch_count = 0;
  int n_cell_ops = 0;
  int n_range_errs = 0;
  int n_generations = 0;
  int n_other = 0;
  int n_settings = 0;
  int quiet_cycles = 0;
  int feed_burst = 0;
  int sink_burst = 0;
  bit hold_off_req = 1'b0;
  int win_row0, win_rspan, win_col0, win_cspan;

  life_automaton_generation uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int rows_in_use();
    return (cfg_rows > GRID_R) ? GRID_R : int'(cfg_rows);
  endfunction

  function automatic int cols_in_use();
    return (cfg_cols > GRID_C) ? GRID_C : int'(cfg_cols);
  endfunction

  // Replace the grid in use with its next generation; border cells count as dead
  function automatic void step_generation();
    bit [GRID_C-1:0] nxt [GRID_R];
    int ur, uc, n, rr, cc;
    ur = rows_in_use();
    uc = cols_in_use();
    nxt = life_rows;
    for (int r = 0; r < ur; r++) begin
      for (int c = 0; c < uc; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < ur && cc >= 0 && cc < uc)
              n += life_rows[rr][cc];
          end
        end
        if (life_rows[r][c])
          nxt[r][c] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
        else
          nxt[r][c] = (n == BIRTH_COUNT);
      end
    end
    life_rows = nxt;
  endfunction

  // Apply one command to the predicted grid and return the expected result
  function automatic lag_out_t predict_cell_op(lag_in_t op);
    lag_out_t res;
    res = '0;
    case (op.cmd)
      CMD_WRITE, CMD_READ: begin
        n_cell_ops++;
        if (int'(op.cell_row) >= rows_in_use() || int'(op.cell_col) >= cols_in_use()) begin
          res.range_error = 1'b1;
          n_range_errs++;
        end else if (op.cmd == CMD_WRITE) begin
          life_rows[op.cell_row][op.cell_col] = op.cell_value;
        end else begin
          res.read_value = life_rows[op.cell_row][op.cell_col];
        end
      end
      CMD_ADVANCE: begin
        n_generations++;
        step_generation();
      end
      default: n_other++;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic plan_row_t plan_op(logic [CMD_W-1:0] cmd, int row, int col, bit val,
                                        bit known = 1'b0, bit rd = 1'b0, bit err = 1'b0);
    plan_row_t p;
    p = '{default: '0};
    p.op.cmd = cmd;
    p.op.cell_row = ROW_FIELD_W'(row);
    p.op.cell_col = COL_FIELD_W'(col);
    p.op.cell_value = val;
    p.known = known;
    p.want.read_value = rd;
    p.want.range_error = err;
    return p;
  endfunction

  function automatic plan_row_t plan_grid(int rows, int cols);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.rows = CFG_W'(rows);
    p.cols = CFG_W'(cols);
    return p;
  endfunction

  // Mostly coordinates inside a small window of the grid in use, some anywhere
  function automatic lag_in_t random_cell_op();
    lag_in_t op;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      op.cmd = CMD_WRITE;
    else if (pick < 80)
      op.cmd = CMD_READ;
    else if (pick < 94)
      op.cmd = CMD_ADVANCE;
    else
      op.cmd = CMD_UNUSED;
    op.cell_value = 1'($urandom_range(0, 1));
    if (win_rspan == 0 || win_cspan == 0 || $urandom_range(0, 6) == 0) begin
      op.cell_row = ROW_FIELD_W'($urandom_range(0, (1 << ROW_FIELD_W) - 1));
      op.cell_col = COL_FIELD_W'($urandom_range(0, (1 << COL_FIELD_W) - 1));
    end else begin
      op.cell_row = ROW_FIELD_W'(win_row0 + $urandom_range(0, win_rspan - 1));
      op.cell_col = COL_FIELD_W'(win_col0 + $urandom_range(0, win_cspan - 1));
    end
    return op;
  endfunction

  // Offer one command after a random gap; return at the edge that takes it
  task automatic send_cell_op(lag_in_t op, bit known, lag_out_t want);
    int gap;
    if (feed_burst > 0) begin
      feed_burst--;
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      feed_burst = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_wants.push_back('{known, want});
    in_data  <= op;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain outstanding results, then write both size registers
  task automatic set_grid(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    cfg_valid <= 1'b1;
    cfg_index <= REG_GRID_ROWS;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_GRID_COLS;
    cfg_data  <= cols;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // Scoreboard: check results, track register writes, predict accepted commands
  always @(posedge clk) begin
    cell_expect_t exp_item;
    typed_want_t  tw;
    lag_out_t     pred;
    if (rst) begin
      life_rows = '{default: '0};
      cfg_rows  = CFG_RESET;
      cfg_cols  = CFG_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with no command outstanding");
        end else begin
          exp_item = expected_results.pop_front();
          if (out_data.read_value !== exp_item.want.read_value)
            report_mismatch($sformatf("cmd %0d (%0d,%0d): read_value %b, expected %b",
              exp_item.op.cmd, exp_item.op.cell_row, exp_item.op.cell_col,
              out_data.read_value, exp_item.want.read_value));
          if (out_data.range_error !== exp_item.want.range_error)
            report_mismatch($sformatf("cmd %0d (%0d,%0d): range_error %b, expected %b",
              exp_item.op.cmd, exp_item.op.cell_row, exp_item.op.cell_col,
              out_data.range_error, exp_item.want.range_error));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_ROWS)
          cfg_rows = cfg_data;
        else
          cfg_cols = cfg_data;
      end
      if (in_valid && !in_stall) begin
        tw = '{1'b0, '0};
        if (typed_wants.size() != 0)
          tw = typed_wants.pop_front();
        pred = predict_cell_op(in_data);
        expected_results.push_back('{in_data, tw.known ? tw.want : pred});
      end
    end
  end

  // Result side: random stalls, calm stretches, and one long hold-off on request
  initial begin : result_sink
    int hold;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end else if (sink_burst > 0) begin
        sink_burst--;
        hold = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        sink_burst = $urandom_range(10, 40);
        hold = 0;
      end else begin
        hold = $urandom_range(0, 16);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_rows [N_PHASES] = '{64, 1, 1, 64, 127, 0, 7, 3, 65, 0};
    int phase_cols [N_PHASES] = '{64, 1, 64, 1, 127, 5, 9, 3, 100, 0};
    int r, c;

    // Directed commands at reset size, then small, empty and oversized grids
    plan.push_back(plan_op(CMD_READ, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0));
    plan.push_back(plan_op(CMD_READ, 63, 63, 1'b0, 1'b1, 1'b0, 1'b0));
    plan.push_back(plan_op(CMD_WRITE, 0, 0, 1'b1, 1'b1, 1'b0, 1'b0));
    plan.push_back(plan_op(CMD_WRITE, 63, 63, 1'b1, 1'b1, 1'b0, 1'b0));
    plan.push_back(plan_op(CMD_READ, 63, 63, 1'b0, 1'b1, 1'b1, 1'b0));
    plan.push_back(plan_op(CMD_UNUSED, 63, 63, 1'b1, 1'b1, 1'b0, 1'b0));
    plan.push_back(plan_op(CMD_WRITE, 10, 9, 1'b1));
    plan.push_back(plan_op(CMD_WRITE, 10, 10, 1'b1));
    plan.push_back(plan_op(CMD_WRITE, 10, 11, 1'b1));
    plan.push_back(plan_op(CMD_ADVANCE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0));
    plan.push_back(plan_op(CMD_READ, 0, 0, 1'b0));
    plan.push_back(plan_op(CMD_READ, 9, 10, 1'b0));
    plan.push_back(plan_op(CMD_READ, 10, 11, 1'b0));
    plan.push_back(plan_grid(5, 3));
    plan.push_back(plan_op(CMD_WRITE, 5, 0, 1'b1, 1'b1, 1'b0, 1'b1));
    plan.push_back(plan_op(CMD_READ, 0, 3, 1'b0, 1'b1, 1'b0, 1'b1));
    plan.push_back(plan_op(CMD_WRITE, 4, 2, 1'b1));
    plan.push_back(plan_op(CMD_WRITE, 4, 1, 1'b1));
    plan.push_back(plan_op(CMD_WRITE, 3, 2, 1'b1));
    plan.push_back(plan_op(CMD_ADVANCE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0));
    plan.push_back(plan_op(CMD_READ, 3, 1, 1'b0));
    plan.push_back(plan_grid(0, 0));
    plan.push_back(plan_op(CMD_READ, 0, 0, 1'b0, 1'b1, 1'b0, 1'b1));
    plan.push_back(plan_op(CMD_WRITE, 0, 0, 1'b1, 1'b1, 1'b0, 1'b1));
    plan.push_back(plan_op(CMD_ADVANCE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0));
    plan.push_back(plan_grid(127, 127));
    plan.push_back(plan_op(CMD_READ, 63, 63, 1'b0));
    plan.push_back(plan_op(CMD_READ, 10, 10, 1'b0));

    // Hold reset, then walk the table
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        set_grid(plan[i].rows, plan[i].cols);
      else
        send_cell_op(plan[i].op, plan[i].known, plan[i].want);
    end

    // Random phases, one grid size each
    for (int p = 0; p < N_PHASES; p++) begin
      r = phase_rows[p];
      c = phase_cols[p];
      if (p == N_PHASES - 1) begin
        r = $urandom_range(1, GRID_R);
        c = $urandom_range(1, GRID_C);
      end
      set_grid(CFG_W'(r), CFG_W'(c));
      win_rspan = (rows_in_use() < 10) ? rows_in_use() : 10;
      win_cspan = (cols_in_use() < 10) ? cols_in_use() : 10;
      win_row0  = $urandom_range(0, rows_in_use() - win_rspan);
      win_col0  = $urandom_range(0, cols_in_use() - win_cspan);
      for (int k = 0; k < OPS_PER_PHASE; k++) begin
        // Back up the block: long result hold-off while commands keep coming
        if (p == 0 && k == 40) begin
          hold_off_req = 1'b1;
          feed_burst = 60;
        end
        send_cell_op(random_cell_op(), 1'b0, '0);
      end
    end

    // Drain and finish
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d cell reads/writes (%0d out of range), %0d generation steps,",
             n_cell_ops, n_range_errs, n_generations);
    $display("%0d unused commands, over %0d grid size settings.", n_other, n_settings);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lag_pkg.sv
rtl/lag_engine.sv
rtl/life_automaton_generation.sv
verif/life_automaton_generation_tb.sv
